// ===== rtl/core/mm64a_pkg.sv =====
// ----------------------------------------------------------------------------
// mm64a_pkg
// Shared types, constants and the microprogram of the MurmurHash64A engine.
// ----------------------------------------------------------------------------
package mm64a_pkg;

	localparam int WORD_W = 64;
	localparam int CNT_W  = 4;
	localparam int LEN_W  = 31;
	localparam int SEED_W = 32;
	localparam int PC_W   = 5;

	localparam logic [63:0] HASH_MUL = 64'hc6a4a7935bd1e995;
	localparam logic [31:0] MUL_LO   = HASH_MUL[31:0];
	localparam logic [31:0] MUL_HI   = HASH_MUL[63:32];
	localparam int          HASH_SHIFT = 47;

	// operand register sources
	localparam logic [2:0] X_HOLD  = 3'd0;
	localparam logic [2:0] X_LEN   = 3'd1;
	localparam logic [2:0] X_WORD  = 3'd2;
	localparam logic [2:0] X_ACCSH = 3'd3; // acc ^ (acc >> 47)
	localparam logic [2:0] X_HXACC = 3'd4; // h ^ acc
	localparam logic [2:0] X_HTAIL = 3'd5; // h ^ masked tail bytes
	localparam logic [2:0] X_HSH   = 3'd6; // h ^ (h >> 47)

	// partial product steps of x * HASH_MUL
	localparam logic [1:0] MUL_NONE = 2'd0;
	localparam logic [1:0] MUL_LL   = 2'd1; // acc  = xlo * mlo
	localparam logic [1:0] MUL_LH   = 2'd2; // acc += (xlo * mhi) << 32
	localparam logic [1:0] MUL_HL   = 2'd3; // acc += (xhi * mlo) << 32

	// running hash writes
	localparam logic [1:0] H_HOLD = 2'd0;
	localparam logic [1:0] H_INIT = 2'd1; // seed ^ acc
	localparam logic [1:0] H_ACC  = 2'd2;

	// jump conditions
	localparam logic [2:0] C_NEVER     = 3'd0;
	localparam logic [2:0] C_ALWAYS    = 3'd1;
	localparam logic [2:0] C_NOT_FIRST = 3'd2;
	localparam logic [2:0] C_CNT_ZERO  = 3'd3;
	localparam logic [2:0] C_PARTIAL   = 3'd4;
	localparam logic [2:0] C_NOT_LAST  = 3'd5;

	localparam logic [PC_W-1:0] LAST_STEP = 5'd26;

	typedef struct packed {
		logic [2:0]      x_sel;
		logic [1:0]      mul_op;
		logic [1:0]      h_sel;
		logic            out_ld;
		logic [2:0]      cond;
		logic [PC_W-1:0] target;
		logic            fin;
	} uword_t;

	typedef struct packed {
		logic first;
		logic last;
		logic cnt_zero;
		logic partial;
		logic out_full;
	} stat_t;

	function automatic uword_t uw(input logic [2:0] x_sel, input logic [1:0] mul_op,
			input logic [1:0] h_sel, input logic out_ld, input logic [2:0] cond,
			input logic [PC_W-1:0] target, input logic fin);
		uword_t w;
		w.x_sel  = x_sel;
		w.mul_op = mul_op;
		w.h_sel  = h_sel;
		w.out_ld = out_ld;
		w.cond   = cond;
		w.target = target;
		w.fin    = fin;
		return w;
	endfunction

	// Microprogram. Every 64-bit multiply by HASH_MUL is three partial steps.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			5'd0:  w = uw(X_LEN,   MUL_NONE, H_HOLD, 1'b0, C_NOT_FIRST, 5'd5,  1'b0);
			5'd1:  w = uw(X_HOLD,  MUL_LL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd2:  w = uw(X_HOLD,  MUL_LH,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd3:  w = uw(X_HOLD,  MUL_HL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd4:  w = uw(X_HOLD,  MUL_NONE, H_INIT, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd5:  w = uw(X_WORD,  MUL_NONE, H_HOLD, 1'b0, C_CNT_ZERO,  5'd20, 1'b0);
			5'd6:  w = uw(X_HOLD,  MUL_NONE, H_HOLD, 1'b0, C_PARTIAL,   5'd15, 1'b0);
			5'd7:  w = uw(X_HOLD,  MUL_LL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd8:  w = uw(X_HOLD,  MUL_LH,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd9:  w = uw(X_HOLD,  MUL_HL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd10: w = uw(X_ACCSH, MUL_NONE, H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd11: w = uw(X_HOLD,  MUL_LL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd12: w = uw(X_HOLD,  MUL_LH,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd13: w = uw(X_HOLD,  MUL_HL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd14: w = uw(X_HXACC, MUL_NONE, H_HOLD, 1'b0, C_ALWAYS,    5'd16, 1'b0);
			5'd15: w = uw(X_HTAIL, MUL_NONE, H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd16: w = uw(X_HOLD,  MUL_LL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd17: w = uw(X_HOLD,  MUL_LH,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd18: w = uw(X_HOLD,  MUL_HL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd19: w = uw(X_HOLD,  MUL_NONE, H_ACC,  1'b0, C_NEVER,     5'd0,  1'b0);
			5'd20: w = uw(X_HOLD,  MUL_NONE, H_HOLD, 1'b0, C_NOT_LAST,  5'd26, 1'b0);
			5'd21: w = uw(X_HSH,   MUL_NONE, H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd22: w = uw(X_HOLD,  MUL_LL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd23: w = uw(X_HOLD,  MUL_LH,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd24: w = uw(X_HOLD,  MUL_HL,   H_HOLD, 1'b0, C_NEVER,     5'd0,  1'b0);
			5'd25: w = uw(X_HOLD,  MUL_NONE, H_HOLD, 1'b1, C_NEVER,     5'd0,  1'b1);
			default: w = uw(X_HOLD, MUL_NONE, H_HOLD, 1'b0, C_NEVER,    5'd0,  1'b1);
		endcase
		return w;
	endfunction

	// low n bytes kept, n in 1..7
	function automatic logic [WORD_W-1:0] tail_mask(input logic [2:0] n);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (3'(i) < n) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/mm64a_in_if.sv =====
// ----------------------------------------------------------------------------
// mm64a_in_if
// Message word channel: valid/ready with one data word and its framing.
// ----------------------------------------------------------------------------
interface mm64a_in_if;
	import mm64a_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data_word;
	logic [CNT_W-1:0]  byte_count;
	logic              first_word;
	logic              last_word;
	logic [LEN_W-1:0]  message_length;

	modport source(output valid, data_word, byte_count, first_word, last_word,
		message_length, input ready);
	modport sink(input valid, data_word, byte_count, first_word, last_word,
		message_length, output ready);
endinterface

// ===== rtl/core/mm64a_out_if.sv =====
// ----------------------------------------------------------------------------
// mm64a_out_if
// Hash result channel: valid/ready with the finalized 64-bit hash.
// ----------------------------------------------------------------------------
interface mm64a_out_if;
	import mm64a_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] hash_value;

	modport source(output valid, hash_value, input ready);
	modport sink(input valid, hash_value, output ready);
endinterface

// ===== rtl/core/mm64a_useq.sv =====
// ----------------------------------------------------------------------------
// mm64a_useq
// Microsequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module mm64a_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mm64a_pkg::stat_t   stat,
	output mm64a_pkg::uword_t  ctrl,
	output logic               busy
);
	import mm64a_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            busy_q;
	uword_t          word;
	logic            stall;
	logic            active;
	logic            taken;

	assign word   = ucode(pc_q);
	assign stall  = word.out_ld && stat.out_full;
	assign active = busy_q && !stall;
	assign ctrl   = active ? word : '0;
	assign busy   = busy_q;

	always_comb begin
		case (word.cond)
			C_NEVER:     taken = 1'b0;
			C_ALWAYS:    taken = 1'b1;
			C_NOT_FIRST: taken = !stat.first;
			C_CNT_ZERO:  taken = stat.cnt_zero;
			C_PARTIAL:   taken = stat.partial;
			C_NOT_LAST:  taken = !stat.last;
			default:     taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q   <= '0;
			busy_q <= 1'b1;
		end else if (active) begin
			if (taken) begin
				pc_q <= word.target;
			end else if (word.fin) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("transaction accepted while sequencer busy");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= LAST_STEP) else $error("step counter left the program");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.fin && !taken) |=> !busy_q) else $error("program end did not release");
endmodule

// ===== rtl/core/mm64a_dpath.sv =====
// ----------------------------------------------------------------------------
// mm64a_dpath
// Datapath: item latch, seed, running hash, one 32x32 multiplier with a
// 64-bit accumulator, operand register and the result register.
// ----------------------------------------------------------------------------
module mm64a_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mm64a_pkg::WORD_W-1:0] word_in,
	input  logic [mm64a_pkg::CNT_W-1:0]  cnt_in,
	input  logic                        first_in,
	input  logic                        last_in,
	input  logic [mm64a_pkg::LEN_W-1:0]  len_in,
	input  logic                        cfg_we,
	input  logic [mm64a_pkg::SEED_W-1:0] cfg_wdata,
	input  mm64a_pkg::uword_t           ctrl,
	output mm64a_pkg::stat_t            stat,
	mm64a_out_if.source                 out_ch
);
	import mm64a_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              first_q;
	logic              last_q;
	logic [LEN_W-1:0]  len_q;
	logic [SEED_W-1:0] seed_q;
	logic [WORD_W-1:0] h_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] out_q;
	logic              out_valid_q;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       prod;

	assign stat.first    = first_q;
	assign stat.last     = last_q;
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.partial  = (cnt_q != '0) && !cnt_q[3];
	assign stat.out_full = out_valid_q && !out_ch.ready;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.hash_value = out_q;

	assign mul_a = (ctrl.mul_op == MUL_HL) ? x_q[63:32] : x_q[31:0];
	assign mul_b = (ctrl.mul_op == MUL_LH) ? MUL_HI : MUL_LO;
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

	always_ff @(posedge clk) begin
		if (start) begin
			word_q  <= word_in;
			cnt_q   <= cnt_in;
			first_q <= first_in;
			last_q  <= last_in;
			len_q   <= len_in;
		end

		case (ctrl.mul_op)
			MUL_LL:  acc_q <= prod;
			MUL_LH,
			MUL_HL:  acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			default: acc_q <= acc_q;
		endcase

		case (ctrl.x_sel)
			X_LEN:   x_q <= {{(WORD_W-LEN_W){1'b0}}, len_q};
			X_WORD:  x_q <= word_q;
			X_ACCSH: x_q <= acc_q ^ (acc_q >> HASH_SHIFT);
			X_HXACC: x_q <= h_q ^ acc_q;
			X_HTAIL: x_q <= h_q ^ (word_q & tail_mask(cnt_q[2:0]));
			X_HSH:   x_q <= h_q ^ (h_q >> HASH_SHIFT);
			default: x_q <= x_q;
		endcase

		if (ctrl.out_ld) begin
			out_q <= acc_q ^ (acc_q >> HASH_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			h_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			case (ctrl.h_sel)
				H_INIT:  h_q <= {{(WORD_W-SEED_W){1'b0}}, seed_q} ^ acc_q;
				H_ACC:   h_q <= acc_q;
				default: h_q <= h_q;
			endcase
			if (ctrl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_ld |-> !(out_valid_q && !out_ch.ready))
		else $error("result register overwritten before transaction");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.out_ld))
		else $error("result valid without a load step");
endmodule

// ===== rtl/core/murmur64a_hash_engine.sv =====
// After acceptance an empty word, a tail and a full word each take their own microcode
// path; a first word adds the length multiply, a last word the finalize multiply. The
// hash is registered by the last step, which stalls while the result is untaken. A new
// item waits until idle; one 32x32 multiplier does each 64-bit multiply in 3 microsteps.
// Reset (arst_n low): sequencer idle, seed and running hash cleared, no result held.
// ----------------------------------------------------------------------------
// murmur64a_hash_engine
// MurmurHash64A over a stream of little-endian 64-bit words, microcoded.
// ----------------------------------------------------------------------------
module murmur64a_hash_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mm64a_pkg::SEED_W-1:0] cfg_wdata,
	mm64a_in_if.sink                     in_ch,
	mm64a_out_if.source                  out_ch
);
	import mm64a_pkg::*;

	logic   busy;
	logic   start;
	uword_t ctrl;
	stat_t  stat;

	assign in_ch.ready = !busy;
	assign start       = in_ch.valid && !busy;

	mm64a_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	mm64a_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.word_in   (in_ch.data_word),
		.cnt_in    (in_ch.byte_count),
		.first_in  (in_ch.first_word),
		.last_in   (in_ch.last_word),
		.len_in    (in_ch.message_length),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_ch    (out_ch)
	);
endmodule
